@@ hdl/stack_with_remove_by_key_top_assert.svh @@
// Assertion macros of the stack with remove by key design, used by its controller.
`ifndef STACK_WITH_REMOVE_BY_KEY_TOP_ASSERT_SVH
`define STACK_WITH_REMOVE_BY_KEY_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low.
`define SWRK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, quiet while rst_n is low.
`define SWRK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/swrk_pkg.sv @@
// Shared types and constants for the stack with remove by key.
package swrk_pkg;

  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Request kinds.
  localparam logic REQ_PUSH   = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_PUSHED    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REMOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DROPPED   = 2'd3;

  // Strobes that the controller sends to every cell of the chain.
  typedef struct packed {
    logic cmp;    // Compare each held word with the key.
    logic prop;   // Move the match-above flag one cell down.
    logic shift;  // Close the gap left by the removed word.
  } cell_ctrl_t;

endpackage

@@ hdl/stack_with_remove_by_key_top.sv @@
// Top level of the stack with remove by key: controller and a chain of DEPTH cells.
// Push: the result word is strobed after the push state; the next request is taken once busy drops.
// Remove: the match flag walks down the chain one cell per cycle, then the result comes
// from the finish state; busy drops as the result is strobed.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the stack at once; stored words are not cleared.
module stack_with_remove_by_key_top #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_req_type,
  input  logic signed [swrk_pkg::DATA_W-1:0]   in_code,
  output logic                                 out_valid,
  output logic [swrk_pkg::STATUS_W-1:0]        out_status,
  output logic signed [swrk_pkg::DATA_W-1:0]   out_code_out,
  output logic [swrk_pkg::OCC_W-1:0]           out_occupancy
);

  localparam int CNTW = $clog2(DEPTH + 1);

  swrk_pkg::cell_ctrl_t         cell_ctrl;
  logic                         push_en;
  logic [CNTW-1:0]              count;
  logic [swrk_pkg::DATA_W-1:0]  key;
  logic                         found;
  logic [swrk_pkg::DATA_W-1:0]  data_w  [DEPTH];
  logic                         above_w [DEPTH];

  // Any hit in the chain has reached the bottom cell by the end of the sweep.
  assign found = above_w[0];

  swrk_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_code       (in_code),
    .found         (found),
    .cell_ctrl     (cell_ctrl),
    .push_en       (push_en),
    .count         (count),
    .key           (key),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_code_out  (out_code_out),
    .out_occupancy (out_occupancy)
  );

  // Cell i holds stack position i, bottom first; each reads the cell above it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                        valid;
    logic                        load;
    logic [swrk_pkg::DATA_W-1:0] up_data;
    logic                        above_in;

    assign valid = (CNTW'(i) < count);
    assign load  = push_en && (count == CNTW'(i));

    if (i == DEPTH - 1) begin : g_top
      assign up_data  = data_w[i];
      assign above_in = 1'b0;
    end else begin : g_mid
      assign up_data  = data_w[i+1];
      assign above_in = above_w[i+1];
    end

    swrk_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .load      (load),
      .valid     (valid),
      .key       (key),
      .up_data   (up_data),
      .above_in  (above_in),
      .data      (data_w[i]),
      .above_out (above_w[i])
    );
  end

endmodule

@@ hdl/swrk_cell.sv @@
// One cell of the stack chain: holds one word and its search flags.
module swrk_cell (
  input  logic                          clk,
  input  swrk_pkg::cell_ctrl_t          ctrl,
  input  logic                          load,
  input  logic                          valid,
  input  logic [swrk_pkg::DATA_W-1:0]   key,
  input  logic [swrk_pkg::DATA_W-1:0]   up_data,
  input  logic                          above_in,
  output logic [swrk_pkg::DATA_W-1:0]   data,
  output logic                          above_out
);

  logic [swrk_pkg::DATA_W-1:0] data_r;
  logic                        hit_r;
  logic                        above_r;

  // Stored word: loaded by a push, or taken from the cell above while closing the gap.
  // Only cells at or above the removed word have no match above them, so they shift.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= key;
    end else if (ctrl.shift && !above_r) begin
      data_r <= up_data;
    end
  end

  // Search flags: local hit, and whether any cell above this one has a hit.
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      hit_r   <= valid && (data_r == key);
      above_r <= 1'b0;
    end else if (ctrl.prop) begin
      above_r <= above_in;
    end
  end

  assign data      = data_r;
  assign above_out = above_r | hit_r;

endmodule

@@ hdl/swrk_ctrl.sv @@
// Request sequencer, entry counter and result registers of the stack.
`include "stack_with_remove_by_key_top_assert.svh"

module swrk_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_req_type,
  input  logic signed [swrk_pkg::DATA_W-1:0]   in_code,
  input  logic                                 found,
  output swrk_pkg::cell_ctrl_t                 cell_ctrl,
  output logic                                 push_en,
  output logic [$clog2(DEPTH+1)-1:0]           count,
  output logic [swrk_pkg::DATA_W-1:0]          key,
  output logic                                 out_valid,
  output logic [swrk_pkg::STATUS_W-1:0]        out_status,
  output logic signed [swrk_pkg::DATA_W-1:0]   out_code_out,
  output logic [swrk_pkg::OCC_W-1:0]           out_occupancy
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int PCW  = (DEPTH > 2) ? $clog2(DEPTH - 1) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_CMP,
    S_PROP,
    S_FIN
  } state_t;

  state_t                       state_r;
  logic [CNTW-1:0]              count_r;
  logic [PCW-1:0]               prop_cnt_r;
  logic [swrk_pkg::DATA_W-1:0]  key_r;
  logic                         out_valid_r;
  logic [swrk_pkg::STATUS_W-1:0] out_status_r;
  logic [swrk_pkg::DATA_W-1:0]  out_code_r;
  logic [swrk_pkg::OCC_W-1:0]   out_occ_r;

  logic            full;
  logic            prop_last;
  logic [CNTW-1:0] count_inc;
  logic [CNTW-1:0] count_dec;

  assign full      = (count_r == CNTW'(DEPTH));
  assign prop_last = (prop_cnt_r == PCW'(DEPTH - 2));
  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  // Strobes to the cell chain follow the state.
  assign cell_ctrl.cmp   = (state_r == S_CMP);
  assign cell_ctrl.prop  = (state_r == S_PROP);
  assign cell_ctrl.shift = (state_r == S_FIN) && found;
  assign push_en         = (state_r == S_PUSH) && !full;

  // Sequencer with its counter and the registered result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      prop_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            key_r   <= in_code;
            state_r <= (in_req_type == swrk_pkg::REQ_PUSH) ? S_PUSH : S_CMP;
          end
        end
        S_PUSH: begin
          out_valid_r <= 1'b1;
          if (full) begin
            out_status_r <= swrk_pkg::STAT_DROPPED;
            out_code_r   <= '0;
            out_occ_r    <= swrk_pkg::OCC_W'(count_r);
          end else begin
            count_r      <= count_inc;
            out_status_r <= swrk_pkg::STAT_PUSHED;
            out_code_r   <= key_r;
            out_occ_r    <= swrk_pkg::OCC_W'(count_inc);
          end
          state_r <= S_IDLE;
        end
        S_CMP: begin
          prop_cnt_r <= '0;
          state_r    <= S_PROP;
        end
        S_PROP: begin
          prop_cnt_r <= prop_cnt_r + 1'b1;
          if (prop_last) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          if (found) begin
            count_r      <= count_dec;
            out_status_r <= swrk_pkg::STAT_REMOVED;
            out_code_r   <= key_r;
            out_occ_r    <= swrk_pkg::OCC_W'(count_dec);
          end else begin
            out_status_r <= swrk_pkg::STAT_NOT_FOUND;
            out_code_r   <= '0;
            out_occ_r    <= swrk_pkg::OCC_W'(count_r);
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign count         = count_r;
  assign key           = key_r;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_code_out  = out_code_r;
  assign out_occupancy = out_occ_r;

  // The entry count never passes the capacity.
  `SWRK_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNTW'(DEPTH), "entry count above capacity")
  // A result word appears only right after a push or a finished search.
  `SWRK_ASSERT_IMP(a_out_origin, out_valid_r,
    $past(state_r) == S_PUSH || $past(state_r) == S_FIN, "result without a request")
  // A removal takes exactly one entry out.
  `SWRK_ASSERT_IMP(a_remove_count, out_valid_r && out_status_r == swrk_pkg::STAT_REMOVED,
    count_r + 1'b1 == $past(count_r), "removal did not drop one entry")
  // The search sweep runs its full length before finishing.
  `SWRK_ASSERT_NXT(a_prop_len, state_r == S_PROP && !prop_last, state_r == S_PROP,
    "search sweep ended early")

endmodule
